FILE: rtl/snbr_pkg.sv
package snbr_pkg;

  localparam int unsigned XW   = 32;
  localparam int unsigned FB   = 16;
  localparam int unsigned DW   = XW + 1;
  localparam int unsigned QW   = XW + FB;
  localparam int unsigned WW   = QW + 3;
  localparam int unsigned CfgIdxW = 2;

  localparam logic signed [XW-1:0] XMax = {1'b0, {(XW-1){1'b1}}};
  localparam logic signed [XW-1:0] XMin = {1'b1, {(XW-1){1'b0}}};

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_EVAL  = 1'b1;

  localparam logic [CfgIdxW-1:0] CFG_ITER_LIMIT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_REL_TOL    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SLOPE_FLR  = 2'd2;

  typedef enum logic [2:0] {
    PH_INIT   = 3'd0,
    PH_RISE   = 3'd1,
    PH_FALL   = 3'd2,
    PH_BRK_A  = 3'd3,
    PH_BRK_B  = 3'd4,
    PH_WIDE_A = 3'd5,
    PH_WIDE_B = 3'd6,
    PH_IDLE   = 3'd7
  } search_phase_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_CALC,
    CS_DONE,
    CS_RESP
  } ctl_state_e;

  typedef enum logic [1:0] {
    ST_EVAL      = 2'd0,
    ST_CONV      = 2'd1,
    ST_OUT       = 2'd2,
    ST_IDLE_EVAL = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    NX_NEWTON,
    NX_MID,
    NX_REFLECT,
    NX_GUARD
  } nx_sel_e;

  function automatic logic signed [XW-1:0] sat_x(input logic signed [WW-1:0] v);
    logic signed [XW-1:0] r;
    if (v > WW'(XMax)) r = XMax;
    else if (v < WW'(XMin)) r = XMin;
    else r = v[XW-1:0];
    return r;
  endfunction

endpackage

FILE: rtl/snbr_if.sv
interface snbr_req_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic signed [snbr_pkg::XW-1:0]    target_value;
  logic signed [snbr_pkg::XW-1:0]    start_x;
  logic signed [snbr_pkg::XW-1:0]    f_value;
  logic signed [snbr_pkg::XW-1:0]    f_slope;
  modport source (output valid, req_type, target_value, start_x, f_value, f_slope,
                  input ready);
  modport sink (input valid, req_type, target_value, start_x, f_value, f_slope,
                output ready);
endinterface

interface snbr_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [snbr_pkg::XW-1:0]    next_x;
  logic [1:0]                        status;
  modport source (output valid, next_x, status, input ready);
  modport sink (input valid, next_x, status, output ready);
endinterface

interface snbr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [snbr_pkg::CfgIdxW-1:0]      index;
  logic [31:0]                       data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/snbr_div.sv
module snbr_div #(
  parameter int unsigned DvdW = 48,
  parameter int unsigned DvsW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DvdW-1:0] dividend_i,
  input  logic [DvsW-1:0] divisor_i,
  output logic            done_o,
  output logic [DvdW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(DvdW);
  localparam logic [CntW-1:0] Last = CntW'(DvdW - 1);

  logic [DvdW-1:0] quot_q, quot_d;
  logic [DvsW-1:0] rem_q, rem_d, dvs_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DvsW:0]   trial, diff;
  logic            ge;

  // one quotient bit per cycle, restoring
  assign trial = {rem_q, quot_q[DvdW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quot_d = {quot_q[DvdW-2:0], ge};
      rem_d  = ge ? diff[DvsW-1:0] : trial[DvsW-1:0];
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == Last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) dvs_q <= divisor_i;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: rtl/safeguarded_newton_bisection_root_top.sv
// channel  dir  handshake      word
// req_i    in   valid/ready    req_type, target_value, start_x, f_value, f_slope
// rsp_o    out  valid/ready    next_x, status
// cfg_i    in   valid/ready    index, data (ready always high)
//
// start word, or evaluation while idle: the result goes from res_x_q to rsp_o via CS_RESP,
//   and the next word is accepted once control is back in CS_IDLE
// evaluation: the result waits on the serial divider (one quotient bit per cycle over
//   the 48-bit scaled dividend) and req_i stays not ready until it is loaded into rsp_o;
//   the tolerance product runs alongside it
// rsp_o is a registered stage: a new word is taken while a result waits there, and a
//   second finished result holds in place and stalls req_i until rsp_o drains
// reset clears control, search state and the config registers to their defaults, not data registers
module safeguarded_newton_bisection_root_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  snbr_req_if.sink    req_i,
  snbr_rsp_if.source  rsp_o,
  snbr_cfg_if.sink    cfg_i
);

  localparam int unsigned XW = snbr_pkg::XW;
  localparam int unsigned DW = snbr_pkg::DW;
  localparam int unsigned QW = snbr_pkg::QW;
  localparam int unsigned WW = snbr_pkg::WW;
  localparam logic [5:0] MulSteps = 6'd32;

  // configuration registers
  logic [7:0]  iter_limit_q;
  logic [31:0] rel_tol_q;
  logic [30:0] slope_floor_q;

  // search state
  snbr_pkg::search_phase_e phase_q, phase_d;
  logic signed [XW-1:0] cur_x_q, cur_x_d;
  logic signed [XW-1:0] wanted_q, wanted_d;
  logic [31:0]          scale_q, scale_d;
  logic signed [XW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [7:0]           left_q, left_d;

  // per evaluation work registers
  logic signed [DW-1:0] d_q;
  logic signed [XW-1:0] s_q;
  logic [63:0]          acc_q;
  logic [31:0]          mplier_q;
  logic [5:0]           mul_cnt_q;

  // pending immediate response and output stage
  logic signed [XW-1:0] res_x_q;
  snbr_pkg::status_e    res_st_q;
  logic                 out_valid_q;
  logic signed [XW-1:0] out_x_q;
  snbr_pkg::status_e    out_st_q;

  snbr_pkg::ctl_state_e cs_q, cs_d;
  logic in_fire, load, div_start, div_done, is_eval;
  logic [QW-1:0] quot;

  // ---------------- configuration port
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_limit_q  <= 8'd200;
      rel_tol_q     <= 32'd1;
      slope_floor_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        snbr_pkg::CFG_ITER_LIMIT: iter_limit_q  <= cfg_i.data[7:0];
        snbr_pkg::CFG_REL_TOL:    rel_tol_q     <= cfg_i.data;
        snbr_pkg::CFG_SLOPE_FLR:  slope_floor_q <= cfg_i.data[30:0];
        default: ;
      endcase
    end
  end

  // ---------------- control sequencer
  assign in_fire = req_i.valid && req_i.ready;
  assign is_eval = (req_i.req_type == snbr_pkg::REQ_EVAL) && (phase_q != snbr_pkg::PH_IDLE);

  always_comb begin
    cs_d = cs_q;
    unique case (cs_q)
      snbr_pkg::CS_IDLE: if (in_fire) cs_d = is_eval ? snbr_pkg::CS_CALC : snbr_pkg::CS_RESP;
      snbr_pkg::CS_CALC: if (div_done) cs_d = snbr_pkg::CS_DONE;
      snbr_pkg::CS_DONE: if (load) cs_d = snbr_pkg::CS_IDLE;
      snbr_pkg::CS_RESP: if (load) cs_d = snbr_pkg::CS_IDLE;
      default: cs_d = snbr_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready = (cs_q == snbr_pkg::CS_IDLE);
    load        = ((cs_q == snbr_pkg::CS_DONE) || (cs_q == snbr_pkg::CS_RESP)) &&
                  (!out_valid_q || rsp_o.ready);
    div_start   = in_fire && is_eval;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cs_q <= snbr_pkg::CS_IDLE;
    else         cs_q <= cs_d;
  end

  // ---------------- operands from the incoming word
  logic signed [DW-1:0] d_in, d_in_neg;
  logic signed [XW:0]   s_ext;
  logic [XW:0]          s_abs;
  logic [31:0]          tgt_abs;

  assign d_in     = DW'(req_i.f_value) - DW'(wanted_q);
  assign d_in_neg = -d_in;
  assign s_ext    = (XW+1)'(req_i.f_slope);
  assign s_abs    = s_ext[XW] ? 33'(-s_ext) : 33'(s_ext);
  assign tgt_abs  = req_i.target_value[XW-1] ? 32'(-req_i.target_value)
                                             : 32'(req_i.target_value);

  snbr_div #(.DvdW(QW), .DvsW(XW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({(d_in[DW-1] ? d_in_neg[XW-1:0] : d_in[XW-1:0]), {snbr_pkg::FB{1'b0}}}),
    .divisor_i  (s_abs[XW-1:0]),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // tolerance * scale, shift and add, one multiplier bit per cycle
  logic [32:0] mul_sum;
  assign mul_sum = {1'b0, acc_q[63:32]} + (mplier_q[0] ? {1'b0, rel_tol_q} : 33'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mul_cnt_q <= MulSteps;
    else if (div_start) mul_cnt_q <= '0;
    else if (mul_cnt_q != MulSteps) mul_cnt_q <= mul_cnt_q + 6'd1;
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      acc_q    <= '0;
      mplier_q <= scale_q;
      d_q      <= d_in;
      s_q      <= req_i.f_slope;
    end else if (mul_cnt_q != MulSteps) begin
      acc_q    <= {mul_sum, acc_q[31:1]};
      mplier_q <= {1'b0, mplier_q[31:1]};
    end
  end

  // ---------------- step evaluation
  logic signed [DW-1:0] d_neg_v;
  logic [31:0] mag_d;
  logic [XW:0] s_abs_q;
  logic        d_pos, d_neg, d_zero, s_pos, flat, conv;
  logic signed [WW-1:0] q_signed;
  logic signed [XW-1:0] newton_x;

  assign d_neg_v = -d_q;
  assign mag_d   = d_q[DW-1] ? d_neg_v[XW-1:0] : d_q[XW-1:0];
  assign s_abs_q = s_q[XW-1] ? 33'(-(33'(s_q))) : 33'(s_q);
  assign d_zero  = (d_q == '0);
  assign d_neg   = d_q[DW-1];
  assign d_pos   = !d_neg && !d_zero;
  assign s_pos   = !s_q[XW-1] && (s_q != '0);
  assign flat    = s_abs_q <= {2'b00, slope_floor_q};
  assign conv    = {mag_d, 32'd0} < acc_q;

  assign q_signed = (d_neg ^ s_q[XW-1]) ? -WW'(quot) : WW'(quot);

  always_comb begin
    if (!flat) newton_x = snbr_pkg::sat_x(WW'(cur_x_q) - q_signed);
    else if (d_zero) newton_x = cur_x_q;
    else if (s_pos == d_neg) newton_x = snbr_pkg::XMax;
    else newton_x = snbr_pkg::XMin;
  end

  // bracket bookkeeping and choice of the next x
  snbr_pkg::search_phase_e ph_n;
  logic signed [XW-1:0] lo_n, hi_n, ra, rb, x;
  snbr_pkg::nx_sel_e sel;
  logic crossed;

  assign x = cur_x_q;

  always_comb begin
    lo_n    = lo_q;
    hi_n    = hi_q;
    ph_n    = phase_q;
    sel     = snbr_pkg::NX_NEWTON;
    ra      = lo_q;
    rb      = hi_q;
    crossed = 1'b0;
    unique case (phase_q)
      snbr_pkg::PH_INIT: begin
        lo_n = x;
        hi_n = x;
        ph_n = d_pos ? snbr_pkg::PH_RISE : snbr_pkg::PH_FALL;
      end
      snbr_pkg::PH_RISE, snbr_pkg::PH_FALL: begin
        crossed = (phase_q == snbr_pkg::PH_RISE) ? d_neg : d_pos;
        if (crossed) begin
          sel = snbr_pkg::NX_MID;
          if (phase_q == snbr_pkg::PH_RISE) begin
            if (hi_q > x) begin lo_n = x; ph_n = snbr_pkg::PH_BRK_A; end
            else begin hi_n = x; ph_n = snbr_pkg::PH_BRK_B; end
          end else begin
            if (lo_q < x) begin hi_n = x; ph_n = snbr_pkg::PH_BRK_A; end
            else begin lo_n = x; ph_n = snbr_pkg::PH_BRK_B; end
          end
        end else begin
          if (hi_q > x) lo_n = x;
          else hi_n = x;
          ph_n = (phase_q == snbr_pkg::PH_RISE) ? snbr_pkg::PH_WIDE_A : snbr_pkg::PH_WIDE_B;
        end
      end
      snbr_pkg::PH_BRK_A, snbr_pkg::PH_BRK_B: begin
        sel = snbr_pkg::NX_GUARD;
        if ((phase_q == snbr_pkg::PH_BRK_A) ? d_pos : d_neg) hi_n = x;
        else lo_n = x;
      end
      snbr_pkg::PH_WIDE_A, snbr_pkg::PH_WIDE_B: begin
        crossed = (phase_q == snbr_pkg::PH_WIDE_A) ? d_neg : d_pos;
        if (crossed) begin
          sel = snbr_pkg::NX_MID;
          if (phase_q == snbr_pkg::PH_WIDE_A) begin
            if (hi_q > x) begin lo_n = x; ph_n = snbr_pkg::PH_BRK_A; end
            else begin lo_n = hi_q; hi_n = x; ph_n = snbr_pkg::PH_BRK_B; end
          end else begin
            if (lo_q < x) begin hi_n = x; ph_n = snbr_pkg::PH_BRK_A; end
            else begin lo_n = x; ph_n = snbr_pkg::PH_BRK_B; end
          end
        end else begin
          sel = snbr_pkg::NX_REFLECT;
          priority if (x < lo_q) begin
            lo_n = x; ra = hi_q; rb = x;
          end else if (x > hi_q) begin
            hi_n = x; ra = lo_q; rb = x;
          end else if (phase_q == snbr_pkg::PH_WIDE_A) begin
            ra = lo_q; rb = hi_q;
          end else begin
            ra = hi_q; rb = lo_q;
          end
        end
      end
      snbr_pkg::PH_IDLE: sel = snbr_pkg::NX_NEWTON;
    endcase
  end

  // midpoint truncated toward zero, widening as 2a - b
  logic signed [XW:0]   mid_sum, mid_adj, mid_sh;
  logic signed [XW-1:0] mid_x, refl_x, step_x;
  logic signed [XW+1:0] refl_w;

  assign mid_sum = (XW+1)'(lo_n) + (XW+1)'(hi_n);
  assign mid_adj = mid_sum[XW] ? mid_sum + 33'sd1 : mid_sum;
  assign mid_sh  = mid_adj >>> 1;
  assign mid_x   = mid_sh[XW-1:0];
  assign refl_w  = ((XW+2)'(ra) <<< 1) - (XW+2)'(rb);
  assign refl_x  = snbr_pkg::sat_x(WW'(refl_w));

  always_comb begin
    unique case (sel)
      snbr_pkg::NX_NEWTON:  step_x = newton_x;
      snbr_pkg::NX_MID:     step_x = mid_x;
      snbr_pkg::NX_REFLECT: step_x = refl_x;
      snbr_pkg::NX_GUARD:   step_x = ((newton_x < lo_n) || (newton_x > hi_n)) ? mid_x
                                                                             : newton_x;
      default:              step_x = newton_x;
    endcase
  end

  // ---------------- state update
  logic [7:0] left_dec;
  assign left_dec = left_q - 8'd1;

  always_comb begin
    phase_d  = phase_q;
    cur_x_d  = cur_x_q;
    wanted_d = wanted_q;
    scale_d  = scale_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    left_d   = left_q;
    if (in_fire && (req_i.req_type == snbr_pkg::REQ_START)) begin
      wanted_d = req_i.target_value;
      cur_x_d  = req_i.start_x;
      scale_d  = (tgt_abs == '0) ? 32'd1 : tgt_abs;
      phase_d  = snbr_pkg::PH_INIT;
      left_d   = (iter_limit_q == '0) ? 8'd1 : iter_limit_q;
      lo_d     = '0;
      hi_d     = '0;
    end else if (load && (cs_q == snbr_pkg::CS_DONE)) begin
      left_d = left_dec;
      if (conv) begin
        phase_d = snbr_pkg::PH_IDLE;
      end else begin
        cur_x_d = step_x;
        lo_d    = lo_n;
        hi_d    = hi_n;
        phase_d = (left_dec == '0) ? snbr_pkg::PH_IDLE : ph_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= snbr_pkg::PH_IDLE;
      cur_x_q  <= '0;
      wanted_q <= '0;
      scale_q  <= '0;
      lo_q     <= '0;
      hi_q     <= '0;
      left_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      cur_x_q  <= cur_x_d;
      wanted_q <= wanted_d;
      scale_q  <= scale_d;
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      left_q   <= left_d;
    end
  end

  // immediate responses: start echoes its guess, idle evaluation reports x
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (req_i.req_type == snbr_pkg::REQ_START) begin
        res_x_q  <= req_i.start_x;
        res_st_q <= snbr_pkg::ST_EVAL;
      end else begin
        res_x_q  <= cur_x_q;
        res_st_q <= snbr_pkg::ST_IDLE_EVAL;
      end
    end
  end

  // ---------------- output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (load) out_valid_q <= 1'b1;
    else if (rsp_o.ready) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (cs_q == snbr_pkg::CS_RESP) begin
        out_x_q  <= res_x_q;
        out_st_q <= res_st_q;
      end else if (conv) begin
        out_x_q  <= cur_x_q;
        out_st_q <= snbr_pkg::ST_CONV;
      end else begin
        out_x_q  <= step_x;
        out_st_q <= (left_dec == '0) ? snbr_pkg::ST_OUT : snbr_pkg::ST_EVAL;
      end
    end
  end

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.next_x = out_x_q;
  assign rsp_o.status = out_st_q;

endmodule
